[rtl/fopq_pkg.sv]
// Package with the entry type, result and op codes, and cell control for the fee-ordered queue.
package fopq_pkg;

   localparam int unsigned DepthDefault = 64;
   localparam int unsigned MaxOut       = 64;
   localparam int unsigned CapWidth     = 7;
   localparam logic [CapWidth-1:0] CapReset = 7'd64;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_EMIT   = 2'd2;

   localparam logic [2:0] RC_DONE  = 3'd0;
   localparam logic [2:0] RC_FULL  = 3'd1;
   localparam logic [2:0] RC_MISS  = 3'd2;
   localparam logic [2:0] RC_ENTRY = 3'd3;
   localparam logic [2:0] RC_NONE  = 3'd4;

   localparam logic [1:0] ST_PENDING = 2'd0;

   typedef struct packed {
      logic [31:0] tag;
      logic [31:0] fee;
      logic [31:0] stamp;
      logic [1:0]  status;
   } entry_type;

   typedef enum logic [2:0] {
      CM_HOLD,
      CM_INSERT,
      CM_REMOVE,
      CM_ROT_FWD,
      CM_ROT_BACK
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      entry_type     key;
   } cell_ctl_type;

endpackage

[rtl/fopq_cell.sv]
// One slot of the sorted chain: holds an entry and shifts toward either neighbor.
module fopq_cell (
   input  logic                  clock,
   input  fopq_pkg::cell_ctl_type ctl,
   input  logic                  occ,
   input  fopq_pkg::entry_type   prev_entry,
   input  fopq_pkg::entry_type   next_entry,
   input  logic                  prev_cond,
   input  logic                  prev_hit,
   output fopq_pkg::entry_type   entry,
   output logic                  cond,
   output logic                  hit
);
   import fopq_pkg::*;

   entry_type entry_ff, entry_in;
   logic      below;

   // A stored entry ranks below the key on lower fee, or on a later stamp at equal fee.
   always_comb begin
      if (entry_ff.fee != ctl.key.fee) begin
         below = entry_ff.fee < ctl.key.fee;
      end else begin
         below = entry_ff.stamp > ctl.key.stamp;
      end
   end

   assign cond = !occ || below;
   assign hit  = prev_hit || (occ && entry_ff.tag == ctl.key.tag);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.mode)
         CM_INSERT: begin
            if (prev_cond) begin
               entry_in = prev_entry;
            end else if (cond) begin
               entry_in = ctl.key;
            end
         end
         CM_REMOVE: begin
            if (hit) begin
               entry_in = next_entry;
            end
         end
         CM_ROT_FWD:  entry_in = next_entry;
         CM_ROT_BACK: entry_in = prev_entry;
         default:     entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[rtl/fee_ordered_priority_queue_core.sv]
// Top level of the fee-ordered queue: request handling, emit sequencer and the cell chain.
// Insert and remove are applied in the cycle the item is accepted; their result is
// registered and appears in the following cycle, so they run at one item per cycle
// while the output keeps up. An emit item holds the input through the accept cycle, a
// counting rotation of the chain, a settling step and an emitting reverse rotation,
// plus output stall cycles; with nothing to emit the reverse rotation is skipped.
// Reset is synchronous: the table is emptied and the capacity limit returns to 64.
module fee_ordered_priority_queue_core #(
   parameter int unsigned DEPTH = fopq_pkg::DepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: tx_tag[31:0], fee[63:32], stamp[95:64], entry_status[97:96], want_count[104:98]
   input  logic [111:0] req_tdata,
   // tuser: op[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: out_tag[31:0], out_fee[63:32], out_stamp[95:64], out_status[97:96]
   output logic [103:0] rsp_tdata,
   // tuser: result_code[2:0]
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [6:0]   csr_wdata
);
   import fopq_pkg::*;

   localparam int unsigned FW = $clog2(DEPTH + 1);
   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned CW = (FW > CapWidth) ? FW : CapWidth;
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_COUNT = 2'd1;
   localparam logic [1:0] S_EMIT  = 2'd2;
   localparam logic [1:0] S_NONE  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [CapWidth-1:0] cap_ff;
   logic [IW-1:0]       scan_ff, scan_in;
   logic [FW-1:0]       pend_ff, pend_in;
   logic [6:0]          limit_ff, limit_in;
   logic [6:0]          remain_ff, remain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   entry_type           rsp_entry_ff, rsp_entry_in;
   logic [2:0]          rsp_code_ff, rsp_code_in;
   logic                rsp_last_ff, rsp_last_in;

   cell_ctl_type        ctl;
   entry_type           cells [DEPTH];
   logic [DEPTH-1:0]    conds, hits, occ;
   entry_type           key;
   logic [1:0]          op;
   logic [6:0]          want;
   logic                fire, out_busy, full, scan_live, obs_pending;
   entry_type           obs;
   logic [6:0]          n_take;

   assign key.tag    = req_tdata[31:0];
   assign key.fee    = req_tdata[63:32];
   assign key.stamp  = req_tdata[95:64];
   assign key.status = req_tdata[97:96];
   assign want       = req_tdata[104:98];
   assign op         = req_tuser;

   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !out_busy;
   assign fire       = req_tvalid && req_tready;
   assign full       = (CW'(fill_ff) >= CW'(cap_ff)) || (CW'(fill_ff) >= CW'(DEPTH));

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         assign occ[gi] = CW'(gi) < CW'(fill_ff);
         fopq_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occ        (occ[gi]),
            .prev_entry (cells[(gi + DEPTH - 1) % DEPTH]),
            .next_entry (cells[(gi + 1) % DEPTH]),
            .prev_cond  ((gi == 0) ? 1'b0 : conds[(gi + DEPTH - 1) % DEPTH]),
            .prev_hit   ((gi == 0) ? 1'b0 : hits[(gi + DEPTH - 1) % DEPTH]),
            .entry      (cells[gi]),
            .cond       (conds[gi]),
            .hit        (hits[gi])
         );
      end
   endgenerate

   // Counting pass watches the head cell; the emit pass watches the tail cell.
   assign obs         = (state_ff == S_EMIT) ? cells[DEPTH-1] : cells[0];
   assign scan_live   = FW'(scan_ff) < fill_ff;
   assign obs_pending = scan_live && (obs.status == ST_PENDING);
   assign n_take      = (CW'(pend_ff) < CW'(limit_ff)) ? 7'(pend_ff) : limit_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      limit_in     = limit_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_entry_in = rsp_entry_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      ctl.mode     = CM_HOLD;
      ctl.key      = key;
      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               rsp_entry_in = '0;
               rsp_last_in  = 1'b1;
               priority if (op == OP_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     rsp_code_in = RC_FULL;
                  end else begin
                     rsp_code_in = RC_DONE;
                     ctl.mode    = CM_INSERT;
                     fill_in     = fill_ff + 1'b1;
                  end
               end else if (op == OP_REMOVE) begin
                  rsp_valid_in = 1'b1;
                  if (hits[DEPTH-1]) begin
                     rsp_code_in = RC_DONE;
                     ctl.mode    = CM_REMOVE;
                     fill_in     = fill_ff - 1'b1;
                  end else begin
                     rsp_code_in = RC_MISS;
                  end
               end else if (op == OP_EMIT) begin
                  state_in = S_COUNT;
                  scan_in  = '0;
                  pend_in  = '0;
                  limit_in = (want > 7'(MaxOut)) ? 7'(MaxOut) : want;
               end else begin
                  rsp_valid_in = rsp_valid_ff && !rsp_tready;
               end
            end
         end
         S_COUNT: begin
            ctl.mode = CM_ROT_FWD;
            if (obs_pending) begin
               pend_in = pend_ff + 1'b1;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == IW'(DEPTH - 1)) begin
               if (n_take == '0 && !obs_pending) begin
                  state_in = S_NONE;
               end else begin
                  // Settle the counts from the final observation on the next cycle.
                  state_in = S_EMIT;
               end
               scan_in = IW'(DEPTH - 1);
            end
         end
         S_EMIT: begin
            // On entry, pend holds the total pending count; turn it into a skip count.
            if (remain_ff == '0 && pend_ff != '0 && scan_ff == IW'(DEPTH - 1)
                && limit_ff != 7'h7f) begin
               remain_in = n_take;
               pend_in   = pend_ff - FW'(n_take);
               limit_in  = 7'h7f;
               if (n_take == '0) begin
                  state_in = S_NONE;
               end
            end else if (!(obs_pending && pend_ff == '0 && remain_ff != '0 && out_busy)) begin
               ctl.mode = CM_ROT_BACK;
               scan_in  = scan_ff - 1'b1;
               if (obs_pending) begin
                  if (pend_ff != '0) begin
                     pend_in = pend_ff - 1'b1;
                  end else if (remain_ff != '0) begin
                     remain_in    = remain_ff - 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_code_in  = RC_ENTRY;
                     rsp_entry_in = obs;
                     rsp_last_in  = (remain_ff == 7'd1);
                  end
               end
               if (scan_ff == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_NONE: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = RC_NONE;
               rsp_entry_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         cap_ff       <= CapReset;
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         remain_ff    <= remain_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      pend_ff      <= pend_in;
      limit_ff     <= limit_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_entry_ff.status, rsp_entry_ff.stamp,
                        rsp_entry_ff.fee, rsp_entry_ff.tag};
   assign rsp_tuser  = rsp_code_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(fill_ff) <= CW'(DEPTH))
      else $error("fill count exceeds depth");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      fire |-> state_ff == S_IDLE && !out_busy)
      else $error("item accepted while busy");

   a_plain_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_code_ff != RC_ENTRY |-> rsp_last_ff)
      else $error("status result without last");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      fire && op == OP_INSERT && !full |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("insert did not grow fill count");

endmodule

[tb/fee_ordered_priority_queue_core_tb.sv]
// Self-checking testbench for the fee-ordered priority queue core.
module fee_ordered_priority_queue_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fopq_pkg::*;

   localparam int unsigned Depth      = 64;
   localparam int unsigned CycleLimit = 2000000;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] tag;
      logic [31:0] fee;
      logic [31:0] stamp;
      logic [1:0]  status;
      logic [6:0]  want;
   } request_type;

   typedef struct packed {
      logic [2:0]  code;
      logic [31:0] tag;
      logic [31:0] fee;
      logic [31:0] stamp;
      logic [1:0]  status;
      logic        last;
   } response_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we;
   logic [6:0]   csr_wdata;

   fee_ordered_priority_queue_core #(.DEPTH(Depth)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the table, kept sorted in priority order.
   entry_type    table_q[$];
   entry_type    clear_q[$];
   logic [6:0]   cap_limit;
   request_type  pending_items[$];
   response_type expected_rsps[$];
   int unsigned  error_count;
   int unsigned  rsp_count;
   int unsigned  entry_rsp_count;
   int unsigned  full_count;
   int unsigned  cycle_count;
   int unsigned  burst_left;
   int unsigned  gap_left;
   int unsigned  hold_off;
   bit           hold_request;
   bit           idle_enable;
   logic [31:0]  live_tags[$];

   always begin
      #6 clock = 1'b0;
      #6 clock = 1'b1;
   end

   function automatic response_type plain_rsp(logic [2:0] code);
      response_type r;
      r = '0;
      r.code = code;
      r.last = 1'b1;
      return r;
   endfunction

   // Computes the results of one accepted item and updates the shadow table.
   function automatic void predict_queue(request_type item);
      int pos;
      int picks[$];
      entry_type e;
      response_type r;
      int lim;
      case (item.op)
         OP_INSERT: begin
            if (table_q.size() >= cap_limit || table_q.size() >= Depth) begin
               expected_rsps.push_back(plain_rsp(RC_FULL));
            end else begin
               pos = table_q.size();
               for (int i = 0; i < table_q.size(); i++) begin
                  if (table_q[i].fee != item.fee ? table_q[i].fee < item.fee
                                                 : table_q[i].stamp > item.stamp) begin
                     pos = i;
                     break;
                  end
               end
               e.tag = item.tag;
               e.fee = item.fee;
               e.stamp = item.stamp;
               e.status = item.status;
               table_q.insert(pos, e);
               expected_rsps.push_back(plain_rsp(RC_DONE));
            end
         end
         OP_REMOVE: begin
            pos = -1;
            for (int i = 0; i < table_q.size(); i++) begin
               if (table_q[i].tag == item.tag) begin
                  pos = i;
                  break;
               end
            end
            if (pos < 0) begin
               expected_rsps.push_back(plain_rsp(RC_MISS));
            end else begin
               table_q.delete(pos);
               expected_rsps.push_back(plain_rsp(RC_DONE));
            end
         end
         OP_EMIT: begin
            lim = item.want < MaxOut ? item.want : MaxOut;
            for (int i = 0; i < table_q.size() && picks.size() < lim; i++) begin
               if (table_q[i].status == ST_PENDING) picks.push_back(i);
            end
            if (picks.size() == 0) begin
               expected_rsps.push_back(plain_rsp(RC_NONE));
            end else begin
               for (int k = picks.size() - 1; k >= 0; k--) begin
                  r.code = RC_ENTRY;
                  r.tag = table_q[picks[k]].tag;
                  r.fee = table_q[picks[k]].fee;
                  r.stamp = table_q[picks[k]].stamp;
                  r.status = table_q[picks[k]].status;
                  r.last = (k == 0);
                  expected_rsps.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Driver: bursts of items separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_queue(pending_items.pop_front());
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_items.size() == 0 || hold_request) begin
               req_tvalid <= 1'b0;
            end else if (gap_left != 0 && idle_enable) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_items[0].op;
               req_tdata <= {7'd0, pending_items[0].want, pending_items[0].status,
                             pending_items[0].stamp, pending_items[0].fee,
                             pending_items[0].tag};
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // Receiver: stall pattern of its own, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off != 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (!idle_enable) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ((cycle_count / 7) % 3 != 0) || ($urandom_range(0, 3) == 0);
      end
   end

   // Monitor and scoreboard.
   always @(posedge clock) begin
      response_type got;
      response_type want_rsp;
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.code = rsp_tuser;
            got.tag = rsp_tdata[31:0];
            got.fee = rsp_tdata[63:32];
            got.stamp = rsp_tdata[95:64];
            got.status = rsp_tdata[97:96];
            got.last = rsp_tlast;
            rsp_count++;
            if (got.code == RC_ENTRY) entry_rsp_count++;
            if (got.code == RC_FULL) full_count++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               error_count++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               if (got !== want_rsp) begin
                  $display("%0t: result mismatch, expected code %0d tag %h fee %h stamp %h status %0d last %0b",
                           $time, want_rsp.code, want_rsp.tag, want_rsp.fee, want_rsp.stamp,
                           want_rsp.status, want_rsp.last);
                  $display("%0t:                  actual code %0d tag %h fee %h stamp %h status %0d last %0b",
                           $time, got.code, got.tag, got.fee, got.stamp, got.status, got.last);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      @(posedge clock);
      while (cycle_count < CycleLimit) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic queue_item(logic [1:0] op, logic [31:0] tag, logic [31:0] fee,
                             logic [31:0] stamp, logic [1:0] status, logic [6:0] want);
      request_type item;
      item.op = op;
      item.tag = tag;
      item.fee = fee;
      item.stamp = stamp;
      item.status = status;
      item.want = want;
      if (op == OP_INSERT) live_tags.push_back(tag);
      pending_items.push_back(item);
   endtask

   task automatic drain_all();
      while (pending_items.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      // An emit may still be rotating the chain after its last result.
      repeat (2 * Depth + 8) @(posedge clock);
   endtask

   task automatic write_limit(logic [6:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      cap_limit = value;
   endtask

   function automatic logic [31:0] pick_tag();
      if (live_tags.size() != 0 && $urandom_range(0, 3) != 0)
         return live_tags[$urandom_range(0, live_tags.size() - 1)];
      return $urandom();
   endfunction

   // Random traffic mixing inserts, removes and emits, with an occasional unused op.
   task automatic random_items(int unsigned count, int unsigned fee_span);
      int unsigned sel;
      logic [31:0] fee;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 19);
         fee = fee_span == 0 ? $urandom() : $urandom_range(0, fee_span);
         if (sel < 9) begin
            queue_item(OP_INSERT, $urandom(), fee,
                       $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom(),
                       $urandom_range(0, 4) == 0 ? 2'($urandom_range(1, 3)) : ST_PENDING,
                       7'd0);
         end else if (sel < 14) begin
            queue_item(OP_REMOVE, pick_tag(), $urandom(), $urandom(), 2'($urandom()),
                       7'($urandom()));
         end else if (sel < 19) begin
            queue_item(OP_EMIT, $urandom(), $urandom(), $urandom(), 2'($urandom()),
                       $urandom_range(0, 3) == 0 ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(0, 8)));
         end else begin
            queue_item(2'd3, $urandom(), $urandom(), $urandom(), 2'($urandom()),
                       7'($urandom()));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      hold_off = 0;
      hold_request = 1'b0;
      idle_enable = 1'b1;
      error_count = 0;
      rsp_count = 0;
      entry_rsp_count = 0;
      full_count = 0;
      cap_limit = CapReset;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-table cases, extremes, ties and a small capacity.
      write_limit(7'd3);
      queue_item(OP_EMIT, '0, '0, '0, '0, 7'd5);
      queue_item(OP_REMOVE, 32'hFFFF_FFFF, '0, '0, '0, '0);
      queue_item(OP_INSERT, 32'h1, 32'd100, 32'd5, ST_PENDING, '0);
      queue_item(OP_INSERT, 32'h2, 32'd100, 32'd5, ST_PENDING, '0);
      queue_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, '0);
      queue_item(OP_INSERT, 32'h4, '0, '0, ST_PENDING, '0);
      queue_item(OP_EMIT, '0, '0, '0, '0, 7'd0);
      queue_item(OP_EMIT, '0, '0, '0, '0, 7'd127);
      queue_item(2'd3, 32'h1, '1, '1, 2'd3, 7'd127);
      queue_item(OP_REMOVE, 32'h1, '0, '0, '0, '0);
      queue_item(OP_REMOVE, 32'h1, '0, '0, '0, '0);
      queue_item(OP_INSERT, 32'h5, 32'd100, 32'd4, 2'd1, '0);
      queue_item(OP_INSERT, 32'h6, 32'd100, 32'd6, 2'd2, '0);
      queue_item(OP_EMIT, '1, '1, '1, 2'd3, 7'd64);
      queue_item(OP_REMOVE, 32'hFFFF_FFFF, '0, '0, '0, '0);
      queue_item(OP_REMOVE, 32'h2, '0, '0, '0, '0);
      queue_item(OP_REMOVE, 32'h5, '0, '0, '0, '0);
      queue_item(OP_EMIT, '0, '0, '0, '0, 7'd1);
      drain_all();

      write_limit(7'd0);
      queue_item(OP_INSERT, 32'h7, 32'd1, 32'd1, ST_PENDING, '0);
      drain_all();

      // Long receiver hold-off while the sender keeps offering; fills the table.
      write_limit(7'd64);
      for (int n = 0; n < 66; n++)
         queue_item(OP_INSERT, $urandom(), $urandom_range(0, 7), $urandom_range(0, 3),
                    ST_PENDING, '0);
      queue_item(OP_EMIT, '0, '0, '0, '0, 7'd100);
      hold_off = 400;
      drain_all();

      // Drop the limit below the fill level, then clear the table out again.
      write_limit(7'd1);
      random_items(20, 15);
      drain_all();
      clear_q = table_q;
      foreach (clear_q[i]) queue_item(OP_REMOVE, clear_q[i].tag, '0, '0, '0, '0);
      drain_all();
      live_tags.delete();

      write_limit(7'd12);
      random_items(30, 31);
      drain_all();

      idle_enable = 1'b0;
      write_limit(7'd40);
      random_items(15, 0);
      drain_all();
      idle_enable = 1'b1;

      write_limit(7'd127);
      random_items(25, 1000);
      drain_all();

      $display("Covered %0d results (%0d emitted entries, %0d refused inserts)",
               rsp_count, entry_rsp_count, full_count);
      $display("over capacity limits 0 to 127, ties, hidden statuses and a long stall.");
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

[fee_ordered_priority_queue_core.f]
rtl/fopq_pkg.sv
rtl/fopq_cell.sv
rtl/fee_ordered_priority_queue_core.sv
tb/fee_ordered_priority_queue_core_tb.sv
